@@ rtl/core/bffa_pkg.sv @@
`timescale 1ns / 1ps

package bffa_pkg;

    // slots held in one map word
    localparam int WORD_W  = 8;
    localparam int WORD_LW = $clog2(WORD_W);

    // request kinds
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // result codes
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_NO_FIT = 2'd1;
    localparam logic [1:0] STAT_RANGE  = 2'd2;
    localparam logic [1:0] STAT_DOUBLE = 2'd3;

    typedef logic [WORD_W-1:0] map_word_t;

endpackage

@@ rtl/core/bffa_ram.sv @@
`timescale 1ns / 1ps

module bffa_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/bitmap_first_fit_allocator.sv @@
`timescale 1ns / 1ps

// bitmap first-fit allocator: one used bit per slot, kept 8 slots to a ram word
//
// input channel s_axis_*: one word per request; tuser is the opcode (allocate or
// free), tdata carries start_index and slot_count
// output channel m_axis_*: one word per request; tdata is granted_index, tuser is
// the status (ok, no fit, free out of range, double free)
// config: cfg_wen/cfg_wdata write pool_size; the user must write it only while no
// request is in flight, as the block itself does not enforce this
// reset: the map ram is swept to all-free, one word per cycle; s_axis_tready
// stays low until the sweep is over
//
// the map word ram is the only path to the map, one read and one write per
// cycle: allocate scans the words in order until a fit or the end of the pool,
// then marks the words of the run; free clears the words of its range
// one request at a time; tready is high only while idle
// the result sits in an output register, so the next request is accepted while
// the receiver stalls; a finished request waits for that register to drain
module bitmap_first_fit_allocator
    import bffa_pkg::*;
#(
    parameter int SLOTS = 256
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] start_index, [16:8] slot_count, zero pad
    input  logic        s_axis_tuser,   // [0] opcode

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] granted_index
    output logic [1:0]  m_axis_tuser,   // [1:0] status

    input  logic        cfg_wen,
    input  logic [8:0]  cfg_wdata       // pool_size
);

    localparam int WORDS = (SLOTS + WORD_W - 1) / WORD_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    // slot positions, sizes and counts; holds WORDS*8 and any 9-bit field
    localparam int SWC   = $clog2(WORDS * WORD_W + 1);
    localparam int SW    = (SWC > 10) ? SWC : 10;

    localparam logic [2:0] ST_CLR   = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_RMW   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    // control
    logic [2:0]    state_reg, state_next;
    logic [SW-1:0] rd_ptr_reg, rd_ptr_next;
    logic          rd_vld_reg, rd_vld_next;
    logic [8:0]    pool_size_reg;
    logic          m_valid_reg;

    // payload
    logic          op_reg;
    logic [7:0]    start_reg;
    logic [8:0]    count_reg;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic [SW-1:0] run_len_reg, run_len_next;
    logic [SW-1:0] run_start_reg, run_start_next;
    logic [SW-1:0] lo_reg, lo_next;
    logic [SW-1:0] hi_reg, hi_next;
    logic          mark_reg, mark_next;
    logic          dbl_reg, dbl_next;
    logic [7:0]    granted_reg, granted_next;
    logic [1:0]    status_reg, status_next;
    logic [7:0]    m_data_reg;
    logic [1:0]    m_user_reg;

    logic          s_accept;
    logic          out_load;
    logic [SW-1:0] pool_ext;
    logic [SW-1:0] live_size;
    logic [SW-1:0] words_live;
    logic [SW-1:0] cnt_ext;
    logic [SW-1:0] free_end;
    logic [SW-1:0] last_word;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    map_word_t     ram_wdata;
    map_word_t     ram_rdata;

    // per-word scan and mark/clear logic
    logic [SW-1:0] scan_slot;
    logic [SW-1:0] scan_len;
    logic [SW-1:0] scan_rs;
    logic          scan_found;
    logic [SW-1:0] rmw_slot;
    map_word_t     rmw_mask;
    map_word_t     rmw_word;
    logic          rmw_dbl;

    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign out_load      = (state_reg == ST_DONE) && (!m_valid_reg || m_axis_tready);

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // pool sizes above SLOTS saturate
    assign pool_ext   = SW'(pool_size_reg);
    assign live_size  = (pool_ext > SW'(SLOTS)) ? SW'(SLOTS) : pool_ext;
    assign words_live = (live_size + SW'(WORD_W - 1)) >> WORD_LW;
    assign cnt_ext    = SW'(count_reg);
    assign free_end   = SW'(start_reg) + cnt_ext;
    assign last_word  = (hi_reg - SW'(1)) >> WORD_LW;

    bffa_ram #(
        .DATA_W (WORD_W),
        .DEPTH  (WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_ptr_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // first-fit scan over one map word, carrying the free run across words
    always_comb
    begin
        scan_len   = run_len_reg;
        scan_rs    = run_start_reg;
        scan_found = 1'b0;
        scan_slot  = '0;
        for (int b = 0; b < WORD_W; b++)
        begin
            scan_slot = SW'({rd_idx_reg, WORD_LW'(b)});
            if (!scan_found && (scan_slot < live_size))
            begin
                if (ram_rdata[b])
                begin
                    scan_len = '0;
                    scan_rs  = scan_slot + SW'(1);
                end
                else
                begin
                    scan_len = scan_len + SW'(1);
                    if (scan_len >= cnt_ext)
                    begin
                        scan_found = 1'b1;
                    end
                end
            end
        end
    end

    // mark or clear the part of [lo, hi) that falls in this word
    always_comb
    begin
        rmw_slot = '0;
        for (int b = 0; b < WORD_W; b++)
        begin
            rmw_slot    = SW'({rd_idx_reg, WORD_LW'(b)});
            rmw_mask[b] = (rmw_slot >= lo_reg) && (rmw_slot < hi_reg);
        end
        rmw_word = mark_reg ? (ram_rdata | rmw_mask) : (ram_rdata & ~rmw_mask);
        rmw_dbl  = |(rmw_mask & ~ram_rdata);
    end

    always_comb
    begin
        state_next     = state_reg;
        rd_ptr_next    = rd_ptr_reg;
        rd_vld_next    = rd_vld_reg;
        rd_idx_next    = rd_idx_reg;
        run_len_next   = run_len_reg;
        run_start_next = run_start_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mark_next      = mark_reg;
        dbl_next       = dbl_reg;
        granted_next   = granted_reg;
        status_next    = status_reg;
        ram_we         = 1'b0;
        ram_waddr      = rd_idx_reg;
        ram_wdata      = rmw_word;

        unique case (state_reg)
            ST_CLR:
            begin
                // reset sweep, one word per cycle
                ram_we      = 1'b1;
                ram_waddr   = rd_ptr_reg[AW-1:0];
                ram_wdata   = '0;
                rd_ptr_next = rd_ptr_reg + SW'(1);
                if (rd_ptr_reg == SW'(WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                granted_next   = '0;
                status_next    = STAT_OK;
                rd_ptr_next    = '0;
                rd_vld_next    = 1'b0;
                run_len_next   = '0;
                run_start_next = '0;
                dbl_next       = 1'b0;
                if (op_reg == OP_ALLOC)
                begin
                    state_next = ST_SCAN;
                end
                else if (free_end > live_size)
                begin
                    status_next = STAT_RANGE;
                    state_next  = ST_DONE;
                end
                else if (count_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    lo_next     = SW'(start_reg);
                    hi_next     = free_end;
                    mark_next   = 1'b0;
                    rd_ptr_next = SW'(start_reg) >> WORD_LW;
                    state_next  = ST_RMW;
                end
            end
            ST_SCAN:
            begin
                rd_vld_next = 1'b0;
                if (rd_vld_reg && scan_found)
                begin
                    granted_next = scan_rs[7:0];
                    if (count_reg == '0)
                    begin
                        // zero count: first free slot, nothing marked
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        lo_next     = scan_rs;
                        hi_next     = scan_rs + cnt_ext;
                        mark_next   = 1'b1;
                        rd_ptr_next = scan_rs >> WORD_LW;
                        state_next  = ST_RMW;
                    end
                end
                else if (!rd_vld_reg && (rd_ptr_reg >= words_live))
                begin
                    status_next = STAT_NO_FIT;
                    state_next  = ST_DONE;
                end
                else
                begin
                    if (rd_vld_reg)
                    begin
                        run_len_next   = scan_len;
                        run_start_next = scan_rs;
                    end
                    if (rd_ptr_reg < words_live)
                    begin
                        rd_ptr_next = rd_ptr_reg + SW'(1);
                        rd_vld_next = 1'b1;
                        rd_idx_next = rd_ptr_reg[AW-1:0];
                    end
                end
            end
            ST_RMW:
            begin
                // read word k+1 while word k is written back
                rd_vld_next = 1'b0;
                if (rd_vld_reg)
                begin
                    ram_we   = 1'b1;
                    dbl_next = dbl_reg | rmw_dbl;
                end
                if (rd_vld_reg && (rd_idx_reg == last_word[AW-1:0]))
                begin
                    if (!mark_reg && (dbl_reg || rmw_dbl))
                    begin
                        status_next = STAT_DOUBLE;
                    end
                    state_next = ST_DONE;
                end
                else if (rd_ptr_reg <= last_word)
                begin
                    rd_ptr_next = rd_ptr_reg + SW'(1);
                    rd_vld_next = 1'b1;
                    rd_idx_next = rd_ptr_reg[AW-1:0];
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            rd_ptr_reg    <= '0;
            rd_vld_reg    <= 1'b0;
            pool_size_reg <= 9'd256;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_ptr_reg <= rd_ptr_next;
            rd_vld_reg <= rd_vld_next;
            if (cfg_wen)
            begin
                pool_size_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            op_reg    <= s_axis_tuser;
            start_reg <= s_axis_tdata[7:0];
            count_reg <= s_axis_tdata[16:8];
        end
        rd_idx_reg    <= rd_idx_next;
        run_len_reg   <= run_len_next;
        run_start_reg <= run_start_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mark_reg      <= mark_next;
        dbl_reg       <= dbl_next;
        granted_reg   <= granted_next;
        status_reg    <= status_next;
        if (out_load)
        begin
            m_data_reg <= granted_reg;
            m_user_reg <= status_reg;
        end
    end

    // the map is never touched while waiting for a request
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !ram_we)
        else $error("map write while idle");

    // an accepted request always goes to the check state first
    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> state_reg == ST_CHECK)
        else $error("accepted request did not enter check");

    // write-back never runs past the last word of the range
    a_rmw_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg == ST_RMW) |-> SW'(ram_waddr) <= last_word)
        else $error("write-back beyond range");

    // only a successful request carries a nonzero index
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != STAT_OK) |-> m_axis_tdata == '0)
        else $error("failed request with nonzero index");

endmodule

@@ test/tb_bitmap_first_fit_allocator.sv @@
`timescale 1ns / 1ps

module tb_bitmap_first_fit_allocator
    import bffa_pkg::*;
();

    localparam int SLOTS = 256;

    // one request word as it enters the block
    typedef struct {
        logic       opcode;
        logic [7:0] start_index;
        logic [8:0] slot_count;
    } slot_request_t;

    // one result word as it leaves the block
    typedef struct {
        logic [7:0] granted_index;
        logic [1:0] status;
    } slot_result_t;

    // a run handed out by a predicted allocation, kept so it can be freed later
    typedef struct {
        int unsigned start;
        int unsigned count;
    } slot_run_t;

    // slot map predictor plus the queue of results still owed by the block
    class alloc_scoreboard;
        bit           used_map [SLOTS];
        int unsigned  pool_size;
        slot_result_t owed_results [$];
        slot_run_t    granted_runs [$];
        int           errors;

        function new();
            pool_size = 256;
            errors    = 0;
            foreach (used_map[i])
                used_map[i] = 1'b0;
        endfunction

        // oversized pool saturates to the map depth
        function int unsigned live_slots();
            return (pool_size > SLOTS) ? SLOTS : pool_size;
        endfunction

        function void set_pool(logic [8:0] value);
            pool_size = 32'(value);
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        function void flag(string what);
            errors++;
            if (errors <= 10)
                $display("%0t: %s", $time, what);
        endfunction

        // work out the result of one accepted request and update the map
        function void note_request(slot_request_t req);
            slot_result_t res;
            slot_run_t    run;
            int unsigned  size;
            int unsigned  start;
            int unsigned  count;
            int unsigned  run_start;
            int unsigned  run_len;
            int unsigned  i;
            bit           found;
            bit           touched_free;

            res.granted_index = '0;
            res.status        = STAT_OK;
            size  = live_slots();
            start = 32'(req.start_index);
            count = 32'(req.slot_count);

            if (req.opcode == OP_ALLOC)
            begin
                // first fit: restart the run after every used slot
                run_start = 0;
                run_len   = 0;
                found     = 1'b0;
                for (i = 0; i < size && !found; i++)
                begin
                    if (used_map[i])
                    begin
                        run_len   = 0;
                        run_start = i + 1;
                    end
                    else
                    begin
                        run_len++;
                        if (run_len >= count)
                            found = 1'b1;
                    end
                end
                if (found)
                begin
                    for (i = run_start; i < run_start + count; i++)
                        used_map[i] = 1'b1;
                    res.granted_index = run_start[7:0];
                    if (count != 0)
                    begin
                        run.start = run_start;
                        run.count = count;
                        granted_runs.push_back(run);
                    end
                end
                else
                begin
                    res.status = STAT_NO_FIT;
                end
            end
            else if (start + count > size)
            begin
                res.status = STAT_RANGE;
            end
            else
            begin
                // a double free still clears the whole range
                touched_free = 1'b0;
                for (i = start; i < start + count; i++)
                begin
                    if (!used_map[i])
                        touched_free = 1'b1;
                    used_map[i] = 1'b0;
                end
                if (touched_free)
                    res.status = STAT_DOUBLE;
            end
            owed_results.push_back(res);
        endfunction

        function void check_result(logic [7:0] granted_index, logic [1:0] status);
            slot_result_t owed;

            if (owed_results.size() == 0)
            begin
                flag($sformatf("result with nothing owed: index %0d status %0d",
                               granted_index, status));
                return;
            end
            owed = owed_results.pop_front();
            if (granted_index !== owed.granted_index || status !== owed.status)
                flag($sformatf("result mismatch: index exp %0d got %0d, status exp %0d got %0d",
                               owed.granted_index, granted_index, owed.status, status));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;

    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;    // [7:0] start_index, [16:8] slot_count, zero pad
    logic        s_axis_tuser;    // [0] opcode

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;    // [7:0] granted_index
    logic [1:0]  m_axis_tuser;    // [1:0] status

    logic        cfg_wen;
    logic [8:0]  cfg_wdata;

    // idle odds in percent per cycle, and the long receiver hold-off count
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          hold_cycles = 0;

    alloc_scoreboard sb = new();

    bitmap_first_fit_allocator #(
        .SLOTS(SLOTS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // result side: check each word taken, then pick the next ready
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
        m_axis_tready <= rst_n && (hold_cycles == 0) && ($urandom_range(99) >= rx_idle_pct);
    end

    // long receiver hold-off, counted down here so the sender keeps going
    always @(posedge clk)
    begin
        if (hold_cycles != 0)
            hold_cycles <= hold_cycles - 1;
    end

    // safety net against a hung block
    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // offer one request word, maybe after a random gap, and note it once taken
    task automatic send_request(logic op, int unsigned start, int unsigned count);
        slot_request_t req;

        req.opcode      = op;
        req.start_index = start[7:0];
        req.slot_count  = count[8:0];
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, req.slot_count, req.start_index};
        s_axis_tuser  <= req.opcode;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(req);
    endtask

    // stop offering and wait until every owed result has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // pool_size is only written with nothing in flight
    task automatic write_pool(logic [8:0] value);
        wait_drained();
        while (!s_axis_tready)
            @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        sb.set_pool(value);
    endtask

    // mostly well-formed traffic: small allocations and frees of granted runs,
    // with some fully random words mixed in
    task automatic random_request();
        slot_run_t   run;
        int unsigned size;
        int unsigned roll;
        int unsigned pick;
        int unsigned start;
        int unsigned count;

        size = sb.live_slots();
        roll = $urandom_range(99);
        if (roll < 15)
        begin
            send_request(($urandom_range(1) == 1) ? OP_FREE : OP_ALLOC,
                         $urandom_range(255), $urandom_range(256));
        end
        else if (roll < 55 || sb.granted_runs.size() == 0)
        begin
            roll = $urandom_range(9);
            if (roll < 7)
                count = 1 + $urandom_range(size > 8 ? 7 : (size > 1 ? size - 1 : 0));
            else if (roll < 9)
                count = $urandom_range(size / 2);
            else
                count = $urandom_range(256);
            // start_index is ignored on allocate, so it carries noise
            send_request(OP_ALLOC, $urandom_range(255), count);
        end
        else
        begin
            pick = $urandom_range(sb.granted_runs.size() - 1);
            run  = sb.granted_runs[pick];
            sb.granted_runs.delete(pick);
            start = run.start;
            count = run.count;
            // now and then free only part of the run
            if ($urandom_range(9) == 0 && run.count > 1)
            begin
                start = run.start + $urandom_range(run.count - 1);
                count = $urandom_range(1, run.start + run.count - start);
            end
            send_request(OP_FREE, start, count);
        end
    endtask

    // one pool setting, with a sender pause halfway through and an optional receiver hold-off
    task automatic run_phase(logic [8:0] pool, int items, bit hold_off);
        int n;

        write_pool(pool);
        if (hold_off)
            hold_cycles <= 400;
        for (n = 0; n < items; n++)
        begin
            if (n == items / 2)
                wait_drained();
            random_request();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_ALLOC;
        cfg_wen       = 1'b0;
        cfg_wdata     = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: full pool after reset
        send_request(OP_ALLOC, 0, 0);      // zero count gives first free slot
        send_request(OP_ALLOC, 255, 256);  // whole pool in one run
        send_request(OP_ALLOC, 0, 0);      // zero count with nothing free
        send_request(OP_ALLOC, 0, 1);      // no fit
        send_request(OP_FREE, 255, 1);     // top slot
        send_request(OP_FREE, 255, 2);     // runs past the pool
        send_request(OP_FREE, 0, 256);     // touches the freed top slot
        send_request(OP_FREE, 0, 0);       // zero count free
        send_request(OP_FREE, 255, 0);     // zero count free at the pool edge
        send_request(OP_ALLOC, 0, 5);
        send_request(OP_ALLOC, 0, 3);
        send_request(OP_FREE, 2, 2);       // leaves a hole of two
        send_request(OP_ALLOC, 0, 3);      // hole too small, goes past it
        send_request(OP_ALLOC, 0, 2);      // fills the hole
        send_request(OP_FREE, 128, 128);   // mostly free already

        // directed: zero pool
        write_pool(9'd0);
        send_request(OP_ALLOC, 0, 0);
        send_request(OP_FREE, 0, 0);
        send_request(OP_FREE, 0, 1);
        send_request(OP_FREE, 1, 0);

        // directed: pool above the map depth saturates
        write_pool(9'd511);
        send_request(OP_ALLOC, 0, 256);
        send_request(OP_FREE, 0, 256);
        send_request(OP_ALLOC, 0, 256);
        send_request(OP_FREE, 0, 256);

        // map is empty again here
        sb.granted_runs.delete();

        // sender idles lightly, receiver heavily
        tx_idle_pct = 20;
        rx_idle_pct = 74;
        run_phase(9'd256, 200, 1'b0);
        run_phase(9'd8, 150, 1'b0);        // shrink keeps marks above the pool
        run_phase(9'd1, 60, 1'b0);
        run_phase(9'd60, 150, 1'b0);

        // the other way round
        tx_idle_pct = 74;
        rx_idle_pct = 20;
        run_phase(9'd0, 30, 1'b0);
        run_phase(9'd511, 200, 1'b0);
        run_phase(9'd17, 150, 1'b0);
        run_phase(9'd200, 200, 1'b0);

        // no idling; the receiver holds off once so the block backs up
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_phase(9'd255, 200, 1'b1);
        run_phase(9'd2, 60, 1'b0);
        run_phase(9'd100, 200, 1'b0);
        run_phase(9'd256, 350, 1'b0);

        wait_drained();
        // catch any stray result words
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
